// File: rtl/tlhw_pkg.sv
package tlhw_pkg;

  // default timestamp storage width
  localparam int TIME_WIDTH_DEF = 32;

  // width of the frame clock on the input channel
  localparam int NOW_W = 31;

  // width of the age and counter result fields
  localparam int AGE_W = 32;

  // event codes of an input transaction
  typedef enum logic [1:0] {
    MODE_FRAME     = 2'd0,
    MODE_POLL      = 2'd1,
    MODE_TIMING_RST = 2'd2
  } mode_t;

  // frame sources carried in a frame transaction
  typedef enum logic [2:0] {
    KIND_ATTITUDE    = 3'd0,
    KIND_BATTERY     = 3'd1,
    KIND_GPS         = 3'd2,
    KIND_BARO        = 3'd3,
    KIND_VARIO       = 3'd4,
    KIND_FLIGHT_MODE = 3'd5,
    KIND_LINK_STATS  = 3'd6,
    KIND_OTHER       = 3'd7
  } frame_kind_t;

  // link classification reported by a poll
  typedef enum logic [2:0] {
    ST_NO_RADIO = 3'd0,
    ST_WAITING  = 3'd1,
    ST_OK       = 3'd2,
    ST_DEGRADED = 3'd3,
    ST_LOST     = 3'd4
  } link_status_t;

  // configuration register indexes (byte address is 4 * index)
  typedef enum logic [1:0] {
    REG_LOST_TIMEOUT  = 2'd0,
    REG_STALE_ATT     = 2'd1,
    REG_DEGRADED_QUAL = 2'd2
  } reg_index_t;

  localparam int CFG_ADDR_W = 4;

  // register reset values
  localparam logic [15:0] LOST_TIMEOUT_RST  = 16'd2000;
  localparam logic [15:0] STALE_ATT_RST     = 16'd500;
  localparam logic [7:0]  DEGRADED_QUAL_RST = 8'd50;

endpackage

// File: rtl/tlhw_in_if.sv
interface tlhw_in_if;
  import tlhw_pkg::*;

  logic             valid;
  logic             ready;
  logic [1:0]       mode;
  logic [2:0]       frame_kind;
  logic             frame_valid;
  logic [7:0]       uplink_quality;
  logic [NOW_W-1:0] now_ms;
  logic             port_open;

  modport source (
    output valid, mode, frame_kind, frame_valid, uplink_quality, now_ms, port_open,
    input  ready
  );

  modport sink (
    input  valid, mode, frame_kind, frame_valid, uplink_quality, now_ms, port_open,
    output ready
  );

endinterface

// File: rtl/tlhw_out_if.sv
interface tlhw_out_if;
  import tlhw_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    accepted;
  logic [2:0]              link_status;
  logic                    link_healthy;
  logic [AGE_W-1:0]        lost_count;
  logic signed [AGE_W-1:0] since_frame_ms;
  logic signed [AGE_W-1:0] attitude_age_ms;
  logic signed [AGE_W-1:0] gps_age_ms;
  logic signed [AGE_W-1:0] battery_age_ms;
  logic signed [AGE_W-1:0] flight_mode_age_ms;
  logic signed [AGE_W-1:0] baro_age_ms;
  logic signed [AGE_W-1:0] link_age_ms;

  modport source (
    output valid, accepted, link_status, link_healthy, lost_count, since_frame_ms,
           attitude_age_ms, gps_age_ms, battery_age_ms, flight_mode_age_ms,
           baro_age_ms, link_age_ms,
    input  ready
  );

  modport sink (
    input  valid, accepted, link_status, link_healthy, lost_count, since_frame_ms,
           attitude_age_ms, gps_age_ms, battery_age_ms, flight_mode_age_ms,
           baro_age_ms, link_age_ms,
    output ready
  );

endinterface

// File: rtl/telemetry_link_health_watchdog.sv
// channel   | role | handshake      | carries
// ----------+------+----------------+------------------------------------------
// in_ch     | sink | valid / ready  | event: frame, status poll or timing reset
// out_ch    | src  | valid / ready  | one result per event: status, ages, count
// apb port  | sink | psel / penable | lost timeout, stale attitude, min quality
//
// Two register stages: an input register, then the result register. The
// event logic between them (timestamp subtracts, a four-way minimum and the
// classification compares) updates the watchdog state and fills the result.
// One transaction is taken every cycle as long as out_ch keeps taking
// results. When out_ch stalls, one event waits in the input register and
// in_ch drops ready. Reset (rst_n, synchronous) clears the valid bits, the
// timestamp seen bits and link state, and resets the config registers.
module telemetry_link_health_watchdog #(
  parameter int TIME_WIDTH = tlhw_pkg::TIME_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  tlhw_in_if.sink                         in_ch,
  tlhw_out_if.source                      out_ch,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [tlhw_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);
  import tlhw_pkg::*;

  localparam int  NSRC = 7;
  localparam bit  WRAP = (TIME_WIDTH < NOW_W);

  localparam logic [2:0] SRC_ANY  = 3'd0;
  localparam logic [2:0] SRC_ATT  = 3'd1;
  localparam logic [2:0] SRC_GPS  = 3'd2;
  localparam logic [2:0] SRC_BATT = 3'd3;
  localparam logic [2:0] SRC_MODE = 3'd4;
  localparam logic [2:0] SRC_BARO = 3'd5;
  localparam logic [2:0] SRC_LINK = 3'd6;

  // configuration registers
  logic [15:0] lost_timeout_r;
  logic [15:0] stale_att_r;
  logic [7:0]  degraded_qual_r;
  logic        cfg_wr;

  // input register
  logic             s1_valid_r;
  mode_t            s1_mode_r;
  frame_kind_t      s1_kind_r;
  logic             s1_frame_ok_r;
  logic [7:0]       s1_quality_r;
  logic [NOW_W-1:0] s1_now_r;
  logic             s1_port_r;
  logic             s1_adv;
  logic             fire;

  // watchdog state
  logic [TIME_WIDTH-1:0] time_r [NSRC];
  logic [NSRC-1:0]       seen_r;
  logic [NSRC-1:0]       seen_nxt;
  logic [NSRC-1:0]       stamp_en;
  logic                  link_seen_r;
  logic                  link_seen_nxt;
  logic [7:0]            quality_r;
  logic [7:0]            quality_nxt;
  link_status_t          prev_status_r;
  link_status_t          prev_status_nxt;
  logic [AGE_W-1:0]      lost_cnt_r;
  logic [AGE_W-1:0]      lost_cnt_nxt;

  // event logic
  logic [TIME_WIDTH-1:0] now_t;
  logic [TIME_WIDTH-1:0] diff [NSRC];
  logic [AGE_W-1:0]      age_u [NSRC];
  logic [AGE_W-1:0]      age_o [NSRC];
  logic                  newest_found;
  logic [AGE_W-1:0]      newest;
  logic                  link_fresh;
  logic                  att_fresh;
  link_status_t          status;
  logic                  acc;

  // result register
  logic             out_valid_r;
  logic             res_acc_r;
  link_status_t     res_status_r;
  logic             res_healthy_r;
  logic [AGE_W-1:0] res_lost_r;
  logic [AGE_W-1:0] res_age_r [NSRC];

  // apb write and read
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_comb begin
    case (reg_index_t'(paddr[3:2]))
      REG_LOST_TIMEOUT:  prdata = {16'd0, lost_timeout_r};
      REG_STALE_ATT:     prdata = {16'd0, stale_att_r};
      REG_DEGRADED_QUAL: prdata = {24'd0, degraded_qual_r};
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lost_timeout_r  <= LOST_TIMEOUT_RST;
      stale_att_r     <= STALE_ATT_RST;
      degraded_qual_r <= DEGRADED_QUAL_RST;
    end else if (cfg_wr) begin
      case (reg_index_t'(paddr[3:2]))
        REG_LOST_TIMEOUT:  lost_timeout_r  <= pwdata[15:0];
        REG_STALE_ATT:     stale_att_r     <= pwdata[15:0];
        REG_DEGRADED_QUAL: degraded_qual_r <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // pipeline flow control
  assign s1_adv      = !out_valid_r || out_ch.ready;
  assign in_ch.ready = !s1_valid_r || s1_adv;
  assign fire        = s1_valid_r && s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ch.ready) s1_valid_r <= in_ch.valid;
      if (s1_adv) out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_mode_r     <= mode_t'(in_ch.mode);
      s1_kind_r     <= frame_kind_t'(in_ch.frame_kind);
      s1_frame_ok_r <= in_ch.frame_valid;
      s1_quality_r  <= in_ch.uplink_quality;
      s1_now_r      <= in_ch.now_ms;
      s1_port_r     <= in_ch.port_open;
    end
  end

  // ages of every source against the event time
  assign now_t = TIME_WIDTH'(s1_now_r);

  always_comb begin
    for (int i = 0; i < NSRC; i++) begin
      diff[i] = now_t - time_r[i];
      if (!WRAP && (now_t < time_r[i])) diff[i] = '0;
      age_u[i] = AGE_W'(diff[i]);
      age_o[i] = seen_r[i] ? age_u[i] : '1;
    end
  end

  // youngest of attitude, battery, flight mode and gps
  always_comb begin
    newest_found = 1'b0;
    newest       = '0;
    for (int j = 0; j < 4; j++) begin
      logic [2:0] s;
      case (j)
        0:       s = SRC_ATT;
        1:       s = SRC_BATT;
        2:       s = SRC_MODE;
        default: s = SRC_GPS;
      endcase
      if (seen_r[s] && (!newest_found || (age_u[s] < newest))) begin
        newest_found = 1'b1;
        newest       = age_u[s];
      end
    end
  end

  // link classification
  assign link_fresh = link_seen_r && seen_r[SRC_LINK] &&
                      (age_u[SRC_LINK] <= AGE_W'(lost_timeout_r));
  assign att_fresh  = seen_r[SRC_ATT] && (age_u[SRC_ATT] <= AGE_W'(stale_att_r));

  always_comb begin
    if (!s1_port_r) begin
      status = ST_NO_RADIO;
    end else if (!newest_found) begin
      status = ST_WAITING;
    end else if (newest > AGE_W'(lost_timeout_r)) begin
      status = ST_LOST;
    end else if (link_fresh && (quality_r == 8'd0)) begin
      status = ST_LOST;
    end else if ((link_fresh && (quality_r < degraded_qual_r)) || !att_fresh) begin
      status = ST_DEGRADED;
    end else begin
      status = ST_OK;
    end
  end

  // state update for the event in the input register
  always_comb begin
    seen_nxt        = seen_r;
    stamp_en        = '0;
    link_seen_nxt   = link_seen_r;
    quality_nxt     = quality_r;
    prev_status_nxt = prev_status_r;
    lost_cnt_nxt    = lost_cnt_r;
    acc             = 1'b0;
    case (s1_mode_r)
      MODE_FRAME: begin
        stamp_en[SRC_ANY] = 1'b1;
        if (s1_frame_ok_r) begin
          acc = 1'b1;
          case (s1_kind_r)
            KIND_ATTITUDE:    stamp_en[SRC_ATT]  = 1'b1;
            KIND_BATTERY:     stamp_en[SRC_BATT] = 1'b1;
            KIND_GPS:         stamp_en[SRC_GPS]  = 1'b1;
            KIND_BARO:        stamp_en[SRC_BARO] = 1'b1;
            KIND_VARIO:       ;
            KIND_FLIGHT_MODE: stamp_en[SRC_MODE] = 1'b1;
            KIND_LINK_STATS: begin
              stamp_en[SRC_LINK] = 1'b1;
              link_seen_nxt      = 1'b1;
              quality_nxt        = s1_quality_r;
            end
            default: acc = 1'b0;
          endcase
        end
        seen_nxt = seen_r | stamp_en;
      end
      MODE_POLL: begin
        prev_status_nxt = status;
        if (((prev_status_r == ST_OK) || (prev_status_r == ST_DEGRADED)) &&
            (status == ST_LOST)) begin
          lost_cnt_nxt = lost_cnt_r + AGE_W'(1);
        end
      end
      MODE_TIMING_RST: seen_nxt = '0;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r        <= '0;
      link_seen_r   <= 1'b0;
      quality_r     <= '0;
      prev_status_r <= ST_NO_RADIO;
      lost_cnt_r    <= '0;
    end else if (fire) begin
      seen_r        <= seen_nxt;
      link_seen_r   <= link_seen_nxt;
      quality_r     <= quality_nxt;
      prev_status_r <= prev_status_nxt;
      lost_cnt_r    <= lost_cnt_nxt;
    end
  end

  // timestamp store
  always_ff @(posedge clk) begin
    for (int k = 0; k < NSRC; k++) begin
      if (fire && stamp_en[k]) time_r[k] <= now_t;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      res_acc_r  <= acc;
      res_lost_r <= lost_cnt_nxt;
      if (s1_mode_r == MODE_POLL) begin
        res_status_r  <= status;
        res_healthy_r <= (status == ST_OK) || (status == ST_DEGRADED);
        for (int k = 0; k < NSRC; k++) res_age_r[k] <= age_o[k];
      end else begin
        res_status_r  <= ST_NO_RADIO;
        res_healthy_r <= 1'b0;
        for (int k = 0; k < NSRC; k++) res_age_r[k] <= '0;
      end
    end
  end

  assign out_ch.valid              = out_valid_r;
  assign out_ch.accepted           = res_acc_r;
  assign out_ch.link_status        = res_status_r;
  assign out_ch.link_healthy       = res_healthy_r;
  assign out_ch.lost_count         = res_lost_r;
  assign out_ch.since_frame_ms     = res_age_r[SRC_ANY];
  assign out_ch.attitude_age_ms    = res_age_r[SRC_ATT];
  assign out_ch.gps_age_ms         = res_age_r[SRC_GPS];
  assign out_ch.battery_age_ms     = res_age_r[SRC_BATT];
  assign out_ch.flight_mode_age_ms = res_age_r[SRC_MODE];
  assign out_ch.baro_age_ms        = res_age_r[SRC_BARO];
  assign out_ch.link_age_ms        = res_age_r[SRC_LINK];

endmodule
